/* hdl/lavm_pkg.sv */
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared types, register codes and fixed-point helpers of the look-at unit.
// ----------------------------------------------------------------------------
package lavm_pkg;

    typedef logic signed [31:0] t_word;

    localparam int REG_IDX_W = 3;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_TARGET_X = 3'd0;
    localparam t_reg_idx REG_TARGET_Y = 3'd1;
    localparam t_reg_idx REG_TARGET_Z = 3'd2;
    localparam t_reg_idx REG_UP_X     = 3'd3;
    localparam t_reg_idx REG_UP_Y     = 3'd4;
    localparam t_reg_idx REG_UP_Z     = 3'd5;

    localparam int NUM_ENTRIES = 16;
    localparam logic [3:0] LAST_IDX = 4'd15;

    // Normalized magnitudes keep their top bit at this position.
    localparam int NORM_TOP    = 30;
    localparam int SQRT_STEPS  = 32;

    // Rounds half away from zero while dropping frac fraction bits.
    function automatic logic signed [63:0] round_frac(input logic signed [63:0] v,
                                                     input int frac);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? 64'(-v) : 64'(v);
        r = (m + (64'(1) << (frac - 1))) >> frac;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic t_word sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

/* hdl/lavm_if.sv */
// ----------------------------------------------------------------------------
// lavm_if
// Handshake channels of the look-at unit: eye input, entry output, config.
// ----------------------------------------------------------------------------
interface lavm_eye_if;
    import lavm_pkg::*;
    logic  valid;
    logic  ready;
    t_word eye_x;
    t_word eye_y;
    t_word eye_z;
    modport source (output valid, eye_x, eye_y, eye_z, input ready);
    modport sink   (input valid, eye_x, eye_y, eye_z, output ready);
endinterface

interface lavm_entry_if;
    import lavm_pkg::*;
    logic       valid;
    logic       ready;
    logic [3:0] entry_index;
    t_word      entry_value;
    logic       degenerate;
    logic       last_entry;
    modport source (output valid, entry_index, entry_value, degenerate, last_entry,
                    input ready);
    modport sink   (input valid, entry_index, entry_value, degenerate, last_entry,
                    output ready);
endinterface

interface lavm_cfg_if;
    import lavm_pkg::*;
    logic     valid;
    logic     ready;
    t_reg_idx index;
    t_word    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/lavm_norm.sv */
// ----------------------------------------------------------------------------
// lavm_norm
// Pipelined 3-vector normalizer: scale, sum of squares, square root, divide.
// ----------------------------------------------------------------------------
module lavm_norm #(
    parameter int W    = 33,
    parameter int F    = 16,
    parameter int SB_W = 96
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_vec [3],
    input  logic [SB_W-1:0]     i_side,
    output logic                o_valid,
    output logic                o_ok,
    output logic signed [F+1:0] o_unit [3],
    output logic [SB_W-1:0]     o_side
);
    import lavm_pkg::*;

    localparam int NC     = (W + 7) / 8;
    localparam int PW     = $clog2(W);
    localparam int DV     = F + 1;
    localparam int NW     = F + 32;
    localparam int ST_SQ0 = 5;
    localparam int ST_DV0 = ST_SQ0 + SQRT_STEPS + 1;
    localparam int L      = ST_DV0 + DV + 2;
    localparam int LW     = 4 + SB_W;

    logic [L-1:0]    r_vld;
    logic [LW-1:0]   r_line [L];

    logic [W-1:0]    r_a_mag [3];
    logic [W-1:0]    r_b_mag [3];
    logic [NC-1:0]   r_b_cnz;
    logic [2:0]      r_b_cpos [NC];
    logic [W-1:0]    r_c_mag [3];
    logic [PW-1:0]   r_c_pos;
    logic [30:0]     r_d_n [3];
    logic [61:0]     r_e_sq [3];
    logic [30:0]     r_e_n [3];
    logic [63:0]     r_sv [SQRT_STEPS+1];
    logic [63:0]     r_sr [SQRT_STEPS+1];
    logic [30:0]     r_sn [SQRT_STEPS+1][3];
    logic [NW-1:0]   r_dn [DV+1][3];
    logic [31:0]     r_dr [DV+1][3];
    logic [DV-1:0]   r_dq [DV+1][3];
    logic [31:0]     r_dl [DV+1];
    logic signed [F+1:0] r_h_u [3];

    logic            in_zero;
    logic [2:0]      in_neg;
    logic [W-1:0]    b_or;
    logic [NC*8-1:0] b_orp;
    logic [NC-1:0]   b_cnz;
    logic [2:0]      b_cpos [NC];
    logic [PW-1:0]   c_pos;
    logic [30:0]     d_n [3];
    logic [63:0]     sq_v [SQRT_STEPS+1];
    logic [63:0]     sq_r [SQRT_STEPS+1];
    logic [31:0]     sq_len;
    logic [NW-1:0]   g_num [3];
    logic [31:0]     dv_r [DV+1][3];
    logic [DV-1:0]   dv_q [DV+1][3];
    logic [2:0]      h_neg;

    assign in_zero = (i_vec[0] == '0) && (i_vec[1] == '0) && (i_vec[2] == '0);
    assign in_neg  = {i_vec[2][W-1], i_vec[1][W-1], i_vec[0][W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= {in_zero, in_neg, i_side};
            for (int k = 1; k < L; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    // Leading-one search over the OR of the magnitudes, one byte chunk at a time.
    always_comb begin
        b_or  = r_a_mag[0] | r_a_mag[1] | r_a_mag[2];
        b_orp = (NC*8)'(b_or);
        for (int c = 0; c < NC; c++) begin
            b_cnz[c]  = 1'b0;
            b_cpos[c] = '0;
            for (int j = 0; j < 8; j++) begin
                if (b_orp[c*8+j]) begin
                    b_cnz[c]  = 1'b1;
                    b_cpos[c] = 3'(j);
                end
            end
        end
    end

    always_comb begin
        c_pos = '0;
        for (int c = 0; c < NC; c++) begin
            if (r_b_cnz[c]) begin
                c_pos = PW'(c * 8) + PW'(r_b_cpos[c]);
            end
        end
    end

    // One shift per component covers both directions: scale by 2^NORM_TOP, then down.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_n[i] = 31'(({r_c_mag[i], NORM_TOP'(0)}) >> r_c_pos);
        end
    end

    always_comb begin
        logic [63:0] pb;
        logic [63:0] pt;
        sq_v[0] = r_sv[0];
        sq_r[0] = r_sr[0];
        for (int k = 1; k <= SQRT_STEPS; k++) begin
            pb = 64'(1) << (64 - 2 * k);
            pt = r_sr[k-1] + pb;
            if (r_sv[k-1] >= pt) begin
                sq_v[k] = r_sv[k-1] - pt;
                sq_r[k] = (r_sr[k-1] >> 1) + pb;
            end else begin
                sq_v[k] = r_sv[k-1];
                sq_r[k] = r_sr[k-1] >> 1;
            end
        end
    end

    assign sq_len = r_sr[SQRT_STEPS][31:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            g_num[i] = (NW'(r_sn[SQRT_STEPS][i]) << F) + NW'(sq_len >> 1);
        end
    end

    always_comb begin
        logic [32:0] rs;
        logic        ge;
        for (int i = 0; i < 3; i++) begin
            dv_r[0][i] = r_dr[0][i];
            dv_q[0][i] = r_dq[0][i];
        end
        for (int k = 1; k <= DV; k++) begin
            for (int i = 0; i < 3; i++) begin
                rs = {r_dr[k-1][i], r_dn[k-1][i][DV-k]};
                ge = rs >= {1'b0, r_dl[k-1]};
                dv_r[k][i] = ge ? 32'(rs - {1'b0, r_dl[k-1]}) : rs[31:0];
                dv_q[k][i] = {r_dq[k-1][i][DV-2:0], ge};
            end
        end
    end

    assign h_neg = r_line[L-2][SB_W+2:SB_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_mag[i] <= i_vec[i][W-1] ? W'(-i_vec[i]) : W'(i_vec[i]);
                r_b_mag[i] <= r_a_mag[i];
                r_c_mag[i] <= r_b_mag[i];
                r_d_n[i]   <= d_n[i];
                r_e_sq[i]  <= 62'(r_d_n[i]) * 62'(r_d_n[i]);
                r_e_n[i]   <= r_d_n[i];
                r_sn[0][i] <= r_e_n[i];
                r_dn[0][i] <= g_num[i];
                r_dr[0][i] <= 32'(g_num[i] >> DV);
                r_dq[0][i] <= '0;
                r_h_u[i]   <= h_neg[i] ? -$signed({1'b0, r_dq[DV][i]})
                                       : $signed({1'b0, r_dq[DV][i]});
            end
            r_b_cnz  <= b_cnz;
            r_b_cpos <= b_cpos;
            r_c_pos  <= c_pos;
            r_sv[0]  <= 64'(r_e_sq[0]) + 64'(r_e_sq[1]) + 64'(r_e_sq[2]);
            r_sr[0]  <= '0;
            for (int k = 1; k <= SQRT_STEPS; k++) begin
                r_sv[k] <= sq_v[k];
                r_sr[k] <= sq_r[k];
                r_sn[k] <= r_sn[k-1];
            end
            r_dl[0] <= sq_len;
            for (int k = 1; k <= DV; k++) begin
                r_dl[k] <= r_dl[k-1];
                r_dn[k] <= r_dn[k-1];
                r_dr[k] <= dv_r[k];
                r_dq[k] <= dv_q[k];
            end
        end
    end

    assign o_valid = r_vld[L-1];
    assign o_ok    = !r_line[L-1][SB_W+3];
    assign o_side  = r_line[L-1][SB_W-1:0];
    assign o_unit  = r_h_u;

endmodule

/* hdl/lavm_mat.sv */
// ----------------------------------------------------------------------------
// lavm_mat
// Builds the true up vector, the translation column and all sixteen entries.
// ----------------------------------------------------------------------------
module lavm_mat #(
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic                i_ok,
    input  logic signed [F+1:0] i_s [3],
    input  logic signed [F+1:0] i_f [3],
    input  lavm_pkg::t_word     i_eye [3],
    output logic                o_valid,
    output logic                o_degen,
    output lavm_pkg::t_word     o_vals [lavm_pkg::NUM_ENTRIES]
);
    import lavm_pkg::*;

    localparam int FW = F + 2;
    localparam int UW = F + 3;

    logic [4:0]            r_vld;
    logic                  r_ok [5];
    logic signed [FW-1:0]  r_s [4][3];
    logic signed [FW-1:0]  r_f [4][3];
    t_word                 r_eye [2][3];
    logic signed [2*FW-1:0] r1_sf [6];
    logic signed [FW+31:0] r1_se [3];
    logic signed [FW+31:0] r1_fe [3];
    logic signed [UW-1:0]  r2_u [3];
    logic signed [FW+33:0] r2_a;
    logic signed [FW+33:0] r2_b;
    logic signed [UW-1:0]  r3_u [3];
    logic signed [UW+31:0] r3_ue [3];
    t_word                 r3_v12;
    t_word                 r3_v14;
    logic signed [UW-1:0]  r4_u [3];
    logic signed [UW+33:0] r4_c;
    t_word                 r4_v12;
    t_word                 r4_v14;
    t_word                 r5_vals [NUM_ENTRIES];

    logic signed [2*FW:0]  m2_d [3];
    t_word                 m5_vals [NUM_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_comb begin
        m2_d[0] = (2*FW+1)'(r1_sf[0]) - (2*FW+1)'(r1_sf[1]);
        m2_d[1] = (2*FW+1)'(r1_sf[2]) - (2*FW+1)'(r1_sf[3]);
        m2_d[2] = (2*FW+1)'(r1_sf[4]) - (2*FW+1)'(r1_sf[5]);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m5_vals[4*i]   = sat32(64'(r_s[3][i]));
            m5_vals[4*i+1] = sat32(64'(r4_u[i]));
            m5_vals[4*i+2] = sat32(-64'(r_f[3][i]));
            m5_vals[4*i+3] = '0;
        end
        m5_vals[12] = r4_v12;
        m5_vals[13] = sat32(-round_frac(64'(r4_c), F));
        m5_vals[14] = r4_v14;
        m5_vals[15] = t_word'(64'sd1 <<< F);
        if (!r_ok[3]) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                m5_vals[e] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok[0]  <= i_ok;
            for (int k = 1; k < 5; k++) begin
                r_ok[k] <= r_ok[k-1];
            end
            r_s[0]   <= i_s;
            r_f[0]   <= i_f;
            r_eye[0] <= i_eye;
            for (int k = 1; k < 4; k++) begin
                r_s[k] <= r_s[k-1];
                r_f[k] <= r_f[k-1];
            end
            r_eye[1] <= r_eye[0];

            // Stage 1: products for the up cross product and the two dot products.
            r1_sf[0] <= (2*FW)'(i_s[1]) * (2*FW)'(i_f[2]);
            r1_sf[1] <= (2*FW)'(i_s[2]) * (2*FW)'(i_f[1]);
            r1_sf[2] <= (2*FW)'(i_s[2]) * (2*FW)'(i_f[0]);
            r1_sf[3] <= (2*FW)'(i_s[0]) * (2*FW)'(i_f[2]);
            r1_sf[4] <= (2*FW)'(i_s[0]) * (2*FW)'(i_f[1]);
            r1_sf[5] <= (2*FW)'(i_s[1]) * (2*FW)'(i_f[0]);
            for (int i = 0; i < 3; i++) begin
                r1_se[i] <= (FW+32)'(i_s[i]) * (FW+32)'(i_eye[i]);
                r1_fe[i] <= (FW+32)'(i_f[i]) * (FW+32)'(i_eye[i]);
            end

            // Stage 2: round the true up vector, sum the dot products.
            for (int i = 0; i < 3; i++) begin
                r2_u[i] <= UW'(round_frac(64'(m2_d[i]), F));
            end
            r2_a <= (FW+34)'(r1_se[0]) + (FW+34)'(r1_se[1]) + (FW+34)'(r1_se[2]);
            r2_b <= (FW+34)'(r1_fe[0]) + (FW+34)'(r1_fe[1]) + (FW+34)'(r1_fe[2]);

            // Stage 3: up dot eye products; side and forward translations finish.
            for (int i = 0; i < 3; i++) begin
                r3_ue[i] <= (UW+32)'(r2_u[i]) * (UW+32)'(r_eye[1][i]);
            end
            r3_u   <= r2_u;
            r3_v12 <= sat32(-round_frac(64'(r2_a), F));
            r3_v14 <= sat32(round_frac(64'(r2_b), F));

            // Stage 4: sum for the up translation.
            r4_c   <= (UW+34)'(r3_ue[0]) + (UW+34)'(r3_ue[1]) + (UW+34)'(r3_ue[2]);
            r4_u   <= r3_u;
            r4_v12 <= r3_v12;
            r4_v14 <= r3_v14;

            r5_vals <= m5_vals;
        end
    end

    assign o_valid = r_vld[4];
    assign o_degen = !r_ok[4];
    assign o_vals  = r5_vals;

endmodule

/* hdl/lavm_ser.sv */
// ----------------------------------------------------------------------------
// lavm_ser
// Holds one finished matrix and sends its entries out one item at a time.
// ----------------------------------------------------------------------------
module lavm_ser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_degen,
    input  lavm_pkg::t_word      i_vals [lavm_pkg::NUM_ENTRIES],
    output logic                 o_take,
    lavm_entry_if.source         o_entry
);
    import lavm_pkg::*;

    logic       r_busy;
    logic [3:0] r_cnt;
    logic       r_degen;
    t_word      r_vals [NUM_ENTRIES];
    logic       fire;

    assign fire   = r_busy && o_entry.ready;
    // A new matrix loads while the last entry of the current one leaves.
    assign o_take = !r_busy || (fire && (r_cnt == LAST_IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (o_take) begin
            r_busy <= i_valid;
            r_cnt  <= '0;
        end else if (fire) begin
            r_cnt <= r_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_vals  <= i_vals;
            r_degen <= i_degen;
        end
    end

    assign o_entry.valid       = r_busy;
    assign o_entry.entry_index = r_cnt;
    assign o_entry.entry_value = r_vals[r_cnt];
    assign o_entry.degenerate  = r_degen;
    assign o_entry.last_entry  = (r_cnt == LAST_IDX);

endmodule

/* hdl/look_at_view_matrix.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix in signed fixed point, column-major entries.
//
//   Channel   Dir  Payload                                     Item
//   i_eye     in   eye_x, eye_y, eye_z                         one eye position
//   o_entry   out  entry_index, entry_value, degenerate, last  one matrix entry
//   i_cfg     in   index, data                                 one register write
//
// An eye position yields sixteen entry items, one per cycle while the
// output is ready, so the entry serializer limits how often the block
// accepts eye positions.
// Reset is synchronous; it clears the valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lavm_eye_if.sink      i_eye,
    lavm_entry_if.source  o_entry,
    lavm_cfg_if.sink      i_cfg
);
    import lavm_pkg::*;

    localparam int FW    = FRAC_BITS + 2;
    localparam int SW    = FW + 33;
    localparam int SB1_W = 96;
    localparam int SB2_W = 96 + 3 * FW + 1;
    localparam t_word ONE_Q = t_word'(64'sd1 <<< FRAC_BITS);

    t_word r_tgt [3];
    t_word r_up [3];

    logic                r_t0_v;
    logic signed [32:0]  r_t0_d [3];
    logic [SB1_W-1:0]    r_t0_eye;

    logic                n1_v;
    logic                n1_ok;
    logic signed [FW-1:0] n1_f [3];
    logic [SB1_W-1:0]    n1_side;

    logic [1:0]          r_x_v;
    logic signed [FW+31:0] r_x1_p [6];
    logic [SB2_W-1:0]    r_x1_side;
    logic signed [SW-1:0] r_x2_sc [3];
    logic [SB2_W-1:0]    r_x2_side;

    logic                n2_v;
    logic                n2_ok;
    logic signed [FW-1:0] n2_s [3];
    logic [SB2_W-1:0]    n2_side;

    logic signed [FW-1:0] m_f [3];
    t_word               m_eye [3];
    logic                m_v;
    logic                m_degen;
    t_word               m_vals [NUM_ENTRIES];

    logic                take;
    logic                pipe_en;

    assign pipe_en     = !m_v || take;
    assign i_eye.ready = pipe_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt <= '{default: '0};
            r_up  <= '{'0, ONE_Q, '0};
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TARGET_X: r_tgt[0] <= i_cfg.data;
                REG_TARGET_Y: r_tgt[1] <= i_cfg.data;
                REG_TARGET_Z: r_tgt[2] <= i_cfg.data;
                REG_UP_X:     r_up[0]  <= i_cfg.data;
                REG_UP_Y:     r_up[1]  <= i_cfg.data;
                REG_UP_Z:     r_up[2]  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_v <= 1'b0;
            r_x_v  <= '0;
        end else if (pipe_en) begin
            r_t0_v <= i_eye.valid;
            r_x_v  <= {r_x_v[0], n1_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_t0_d[0] <= 33'(r_tgt[0]) - 33'(i_eye.eye_x);
            r_t0_d[1] <= 33'(r_tgt[1]) - 33'(i_eye.eye_y);
            r_t0_d[2] <= 33'(r_tgt[2]) - 33'(i_eye.eye_z);
            r_t0_eye  <= {i_eye.eye_x, i_eye.eye_y, i_eye.eye_z};

            // Side cross product of unit forward with the raw up vector.
            r_x1_p[0] <= (FW+32)'(n1_f[1]) * (FW+32)'(r_up[2]);
            r_x1_p[1] <= (FW+32)'(n1_f[2]) * (FW+32)'(r_up[1]);
            r_x1_p[2] <= (FW+32)'(n1_f[2]) * (FW+32)'(r_up[0]);
            r_x1_p[3] <= (FW+32)'(n1_f[0]) * (FW+32)'(r_up[2]);
            r_x1_p[4] <= (FW+32)'(n1_f[0]) * (FW+32)'(r_up[1]);
            r_x1_p[5] <= (FW+32)'(n1_f[1]) * (FW+32)'(r_up[0]);
            r_x1_side <= {n1_side, n1_f[0], n1_f[1], n1_f[2], n1_ok};

            r_x2_sc[0] <= SW'(r_x1_p[0]) - SW'(r_x1_p[1]);
            r_x2_sc[1] <= SW'(r_x1_p[2]) - SW'(r_x1_p[3]);
            r_x2_sc[2] <= SW'(r_x1_p[4]) - SW'(r_x1_p[5]);
            r_x2_side  <= r_x1_side;
        end
    end

    lavm_norm #(
        .W    (33),
        .F    (FRAC_BITS),
        .SB_W (SB1_W)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_t0_v),
        .i_vec   (r_t0_d),
        .i_side  (r_t0_eye),
        .o_valid (n1_v),
        .o_ok    (n1_ok),
        .o_unit  (n1_f),
        .o_side  (n1_side)
    );

    lavm_norm #(
        .W    (SW),
        .F    (FRAC_BITS),
        .SB_W (SB2_W)
    ) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_x_v[1]),
        .i_vec   (r_x2_sc),
        .i_side  (r_x2_side),
        .o_valid (n2_v),
        .o_ok    (n2_ok),
        .o_unit  (n2_s),
        .o_side  (n2_side)
    );

    assign m_eye[0] = n2_side[SB2_W-1 -: 32];
    assign m_eye[1] = n2_side[SB2_W-33 -: 32];
    assign m_eye[2] = n2_side[SB2_W-65 -: 32];
    assign m_f[0]   = $signed(n2_side[3*FW:2*FW+1]);
    assign m_f[1]   = $signed(n2_side[2*FW:FW+1]);
    assign m_f[2]   = $signed(n2_side[FW:1]);

    lavm_mat #(
        .F (FRAC_BITS)
    ) u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (n2_v),
        .i_ok    (n2_ok && n2_side[0]),
        .i_s     (n2_s),
        .i_f     (m_f),
        .i_eye   (m_eye),
        .o_valid (m_v),
        .o_degen (m_degen),
        .o_vals  (m_vals)
    );

    lavm_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_v),
        .i_degen (m_degen),
        .i_vals  (m_vals),
        .o_take  (take),
        .o_entry (o_entry)
    );

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the look-at unit: a queue-fed driver offers eye
// positions, a clocked predictor computes the sixteen expected entries of
// each accepted item, and a monitor compares every entry with the oldest one.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lavm_pkg::*;

    localparam int FRAC = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 2 * FRAC + 92 + 100;
    localparam t_reg_idx REG_SPARE_6 = 3'd6;
    localparam t_reg_idx REG_SPARE_7 = 3'd7;

    typedef logic signed [63:0] vec3_t [3];

    typedef struct {
        t_word x;
        t_word y;
        t_word z;
    } eye_item_t;

    typedef struct {
        logic [3:0] index;
        t_word      value;
        logic       degenerate;
        logic       last;
    } entry_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lavm_eye_if   eye_ch();
    lavm_entry_if entry_ch();
    lavm_cfg_if   cfg_ch();

    look_at_view_matrix #(.FRAC_BITS(FRAC)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_eye   (eye_ch.sink),
        .o_entry (entry_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #2 i_clk = ~i_clk;

    eye_item_t eye_pending[$];
    entry_t    entries_due[$];
    t_word     regs_copy[6];
    int        errors = 0;
    int        cycle = 0;
    int        eyes_taken = 0;
    logic      eye_took = 1'b0;
    int        hold_left = 0;
    bit        hold_done = 0;

    // ------------------------------------------------------------------
    // Fixed-point prediction
    // ------------------------------------------------------------------
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit unit_vec(input vec3_t c, output vec3_t q);
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] qm;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i] < 0 ? 64'(-c[i]) : 64'(c[i]);
            if (m[i] > mx) mx = m[i];
            q[i] = 0;
        end
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            qm = ((m[i] << FRAC) + (len >> 1)) / len;
            q[i] = c[i] < 0 ? -$signed(qm) : $signed(qm);
        end
        return 1;
    endfunction

    function automatic logic signed [63:0] drop_frac(input logic signed [63:0] v);
        logic [63:0] m;
        m = v < 0 ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic t_word clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic predict_matrix(input eye_item_t e);
        vec3_t eye, d, f, sc, s, u;
        logic signed [63:0] val[16];
        logic signed [63:0] tg[3], up[3];
        bit ok;
        entry_t x;
        eye[0] = e.x; eye[1] = e.y; eye[2] = e.z;
        for (int i = 0; i < 3; i++) begin
            tg[i] = regs_copy[i];
            up[i] = regs_copy[3 + i];
            d[i] = tg[i] - eye[i];
        end
        ok = unit_vec(d, f);
        if (ok) begin
            sc[0] = f[1] * up[2] - f[2] * up[1];
            sc[1] = f[2] * up[0] - f[0] * up[2];
            sc[2] = f[0] * up[1] - f[1] * up[0];
            ok = unit_vec(sc, s);
        end
        if (ok) begin
            u[0] = drop_frac(s[1] * f[2] - s[2] * f[1]);
            u[1] = drop_frac(s[2] * f[0] - s[0] * f[2]);
            u[2] = drop_frac(s[0] * f[1] - s[1] * f[0]);
            for (int i = 0; i < 3; i++) begin
                val[4*i]   = s[i];
                val[4*i+1] = u[i];
                val[4*i+2] = -f[i];
                val[4*i+3] = 0;
            end
            val[12] = -drop_frac(s[0] * eye[0] + s[1] * eye[1] + s[2] * eye[2]);
            val[13] = -drop_frac(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]);
            val[14] = drop_frac(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]);
            val[15] = 64'sd1 << FRAC;
        end else begin
            for (int i = 0; i < 16; i++) val[i] = 0;
        end
        for (int i = 0; i < 16; i++) begin
            x.index = 4'(i);
            x.value = clamp32(val[i]);
            x.degenerate = !ok;
            x.last = (i == 15);
            entries_due.push_back(x);
        end
    endtask

    // ------------------------------------------------------------------
    // Eye driver: accept at the rising edge, offer at the falling edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        eye_took <= i_rst_n && eye_ch.valid && eye_ch.ready;
        if (i_rst_n && eye_ch.valid && eye_ch.ready) begin
            eye_item_t e;
            e.x = eye_ch.eye_x;
            e.y = eye_ch.eye_y;
            e.z = eye_ch.eye_z;
            predict_matrix(e);
            void'(eye_pending.pop_front());
            eyes_taken <= eyes_taken + 1;
        end
    end

    function automatic bit idle_now();
        // A calm window with no idling on either side.
        if (cycle >= 3000 && cycle < 6000) return 0;
        return $urandom_range(0, 99) < 23;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            eye_ch.valid <= 1'b0;
        end else if (eye_ch.valid && !eye_took) begin
            eye_ch.valid <= 1'b1;
        end else if (eye_pending.size() > 0 && !idle_now()) begin
            eye_ch.valid <= 1'b1;
            eye_ch.eye_x <= eye_pending[0].x;
            eye_ch.eye_y <= eye_pending[0].y;
            eye_ch.eye_z <= eye_pending[0].z;
        end else begin
            eye_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Entry sink: ready with random stalls and one long hold-off.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!hold_done && eyes_taken >= 40) begin
            hold_done <= 1;
            hold_left <= 600;
            entry_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            entry_ch.ready <= 1'b0;
        end else begin
            entry_ch.ready <= !idle_now();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && entry_ch.valid && entry_ch.ready) begin
            if (entries_due.size() == 0) begin
                $display("%0t: unexpected entry idx=%0d value=%h", $time,
                         entry_ch.entry_index, entry_ch.entry_value);
                errors <= errors + 1;
            end else begin
                entry_t x;
                x = entries_due.pop_front();
                if (entry_ch.entry_index !== x.index || entry_ch.entry_value !== x.value ||
                    entry_ch.degenerate !== x.degenerate || entry_ch.last_entry !== x.last)
                begin
                    $display("%0t: mismatch exp %0d %h %b %b, got %0d %h %b %b",
                             $time, x.index, x.value, x.degenerate, x.last,
                             entry_ch.entry_index, entry_ch.entry_value,
                             entry_ch.degenerate, entry_ch.last_entry);
                    errors <= errors + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input t_reg_idx idx, input t_word value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx < 6) regs_copy[idx] = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic setup_view(input t_word tx, ty, tz, ux, uy, uz);
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TARGET_Y, ty);
        write_reg(REG_TARGET_Z, tz);
        write_reg(REG_UP_X, ux);
        write_reg(REG_UP_Y, uy);
        write_reg(REG_UP_Z, uz);
    endtask

    task automatic queue_eye(input t_word x, y, z);
        eye_item_t e;
        e.x = x; e.y = y; e.z = z;
        eye_pending.push_back(e);
    endtask

    function automatic t_word small_word();
        return t_word'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
    endfunction

    task automatic queue_random(input int count);
        int mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 9);
            case (mode)
                0, 1, 2, 3: queue_eye($urandom, $urandom, $urandom);
                4, 5: queue_eye(small_word(), small_word(), small_word());
                6: queue_eye(regs_copy[0], regs_copy[1], regs_copy[2]);
                7: queue_eye(regs_copy[0] + small_word(), regs_copy[1] + small_word(),
                             regs_copy[2] + small_word());
                // Eye displaced from the target along y only.
                default: queue_eye(regs_copy[0], regs_copy[1] + small_word(), regs_copy[2]);
            endcase
        end
    endtask

    task automatic settle();
        while (eye_pending.size() > 0 || entries_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        eye_ch.valid = 1'b0;
        eye_ch.eye_x = '0;
        eye_ch.eye_y = '0;
        eye_ch.eye_z = '0;
        entry_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        regs_copy = '{0, 0, 0, 0, 32'sh00010000, 0};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: target at origin, up along y.
        queue_eye(0, 0, 0);
        queue_eye(0, 32'sh00050000, 0);
        queue_eye(32'sh00030000, 32'sh00020000, 32'sh00050000);
        queue_eye(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        queue_eye(32'sh80000000, 32'sh80000000, 32'sh80000000);
        queue_eye(32'sh7fffffff, 32'sh80000000, 32'sh00000001);
        queue_eye(32'sh00000001, 0, 0);
        queue_eye(0, 0, 32'shffffffff);
        settle();

        // Out-of-range indexes must be ignored.
        write_reg(REG_SPARE_6, 32'h12345678);
        write_reg(REG_SPARE_7, 32'hdeadbeef);
        setup_view(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                   32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        queue_eye(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        queue_eye(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        queue_eye(0, 0, 0);
        queue_eye(32'sh80000000, 32'sh80000000, 32'sh80000000);
        settle();

        // Zero up vector: every view is degenerate.
        setup_view(32'sh00010000, 32'sh00020000, 32'sh00030000, 0, 0, 0);
        queue_eye(0, 0, 0);
        queue_eye(32'sh00010000, 32'sh00020000, 32'sh00030000);
        queue_random(10);
        settle();

        setup_view(0, 0, 0, 0, 32'sh00010000, 0);
        queue_random(90);
        settle();

        for (int p = 0; p < 3; p++) begin
            setup_view($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            queue_random(70);
            settle();
        end

        setup_view(small_word(), small_word(), small_word(),
                   small_word(), small_word(), small_word());
        queue_random(80);
        settle();

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
